// ----- design/bcc_pkg.sv -----
package bcc_pkg;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESSED = 2'd1,
    PH_WAITING = 2'd2,
    PH_SECOND  = 2'd3
  } phase_e;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_ACK    = 1'b1
  } kind_e;

  localparam int unsigned TickW = 16;

  // Register indexes, decoded from the word address.
  localparam logic RegLongTicks   = 1'b0;
  localparam logic RegDoubleTicks = 1'b1;

  localparam logic [TickW-1:0] LongTicksRst   = 16'd16;
  localparam logic [TickW-1:0] DoubleTicksRst = 16'd4;

  typedef struct packed {
    phase_e             phase;
    logic [TickW-1:0]   elapsed;
    logic               single_flag;
    logic               double_flag;
    logic               long_flag;
  } bcc_state_t;

  typedef struct packed {
    logic [TickW-1:0] long_ticks;
    logic [TickW-1:0] double_ticks;
  } bcc_cfg_t;

endpackage

// ----- design/bcc_step.sv -----
module bcc_step (
  input  bcc_pkg::bcc_state_t state_i,
  input  bcc_pkg::bcc_cfg_t   cfg_i,
  input  logic                kind_i,
  input  logic                pin_level_i,
  output bcc_pkg::bcc_state_t state_o
);

  logic                        sample;
  logic                        released;
  logic [bcc_pkg::TickW-1:0]   elapsed_inc;
  bcc_pkg::phase_e             phase_nxt;

  assign sample   = (kind_i == bcc_pkg::KIND_SAMPLE);
  assign released = pin_level_i;

  // The count runs in every phase but idle and saturates at all ones.
  always_comb begin
    elapsed_inc = state_i.elapsed;
    if ((state_i.phase != bcc_pkg::PH_IDLE) && !(&state_i.elapsed)) begin
      elapsed_inc = state_i.elapsed + 1'b1;
    end
  end

  // Next phase.
  always_comb begin
    phase_nxt = state_i.phase;
    if (sample) begin
      case (state_i.phase)
        bcc_pkg::PH_IDLE: begin
          if (!released) phase_nxt = bcc_pkg::PH_PRESSED;
        end
        bcc_pkg::PH_PRESSED: begin
          if (released) begin
            if (elapsed_inc < cfg_i.long_ticks) phase_nxt = bcc_pkg::PH_WAITING;
            else                                phase_nxt = bcc_pkg::PH_IDLE;
          end
        end
        bcc_pkg::PH_WAITING: begin
          if (released) begin
            if (elapsed_inc > cfg_i.double_ticks) phase_nxt = bcc_pkg::PH_IDLE;
          end else if (elapsed_inc < cfg_i.double_ticks) begin
            phase_nxt = bcc_pkg::PH_SECOND;
          end
        end
        bcc_pkg::PH_SECOND: begin
          if (released) phase_nxt = bcc_pkg::PH_IDLE;
        end
        default: phase_nxt = bcc_pkg::PH_IDLE;
      endcase
    end
  end

  // Count and flags.
  always_comb begin
    state_o       = state_i;
    state_o.phase = phase_nxt;
    if (!sample) begin
      state_o.single_flag = 1'b0;
      state_o.double_flag = 1'b0;
      state_o.long_flag   = 1'b0;
    end else begin
      state_o.elapsed = elapsed_inc;
      case (state_i.phase)
        bcc_pkg::PH_IDLE: begin
          if (!released) state_o.elapsed = '0;
        end
        bcc_pkg::PH_PRESSED: begin
          if (released) begin
            if (elapsed_inc < cfg_i.long_ticks) state_o.elapsed = '0;
            else                                state_o.long_flag = 1'b1;
          end
        end
        bcc_pkg::PH_WAITING: begin
          if (released && (elapsed_inc > cfg_i.double_ticks)) begin
            state_o.single_flag = 1'b1;
          end
        end
        bcc_pkg::PH_SECOND: begin
          if (released) state_o.double_flag = 1'b1;
        end
        default: state_o.elapsed = elapsed_inc;
      endcase
    end
  end

endmodule

// ----- design/button_click_classifier.sv -----
// Latency: a result appears in the cycle after its request is accepted.
// Throughput: one request per cycle while no result is held back; the state
// update is one pass of logic from state_q into state_q and the result flops.
// Reset: asynchronous, active low; phase idle, count and flags cleared,
// long_click_ticks = 16, double_click_ticks = 4, no result pending.
module button_click_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic        pin_level_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        single_click_o,
  output logic        double_click_o,
  output logic        long_click_o,
  output logic        pressed_now_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  bcc_pkg::bcc_state_t state_q, state_d;
  bcc_pkg::bcc_cfg_t   cfg_q;
  logic                in_fire;
  logic                cfg_wr;
  logic                out_valid_q;
  logic                single_q, double_q, long_q, pressed_q;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_ticks   <= bcc_pkg::LongTicksRst;
      cfg_q.double_ticks <= bcc_pkg::DoubleTicksRst;
    end else if (cfg_wr) begin
      case (paddr[2])
        bcc_pkg::RegLongTicks:   cfg_q.long_ticks   <= pwdata[bcc_pkg::TickW-1:0];
        bcc_pkg::RegDoubleTicks: cfg_q.double_ticks <= pwdata[bcc_pkg::TickW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bcc_pkg::RegLongTicks:   prdata = {16'd0, cfg_q.long_ticks};
      bcc_pkg::RegDoubleTicks: prdata = {16'd0, cfg_q.double_ticks};
      default:                 prdata = '0;
    endcase
  end

  bcc_step u_step (
    .state_i     (state_q),
    .cfg_i       (cfg_q),
    .kind_i      (kind_i),
    .pin_level_i (pin_level_i),
    .state_o     (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '{phase: bcc_pkg::PH_IDLE, elapsed: '0,
                       single_flag: 1'b0, double_flag: 1'b0, long_flag: 1'b0};
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) state_q <= state_d;
      if (in_ready_o) out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      single_q  <= state_d.single_flag;
      double_q  <= state_d.double_flag;
      long_q    <= state_d.long_flag;
      pressed_q <= !pin_level_i;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign single_click_o = single_q;
  assign double_click_o = double_q;
  assign long_click_o   = long_q;
  assign pressed_now_o  = pressed_q;

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("accepted request produced no result");

  a_ack_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && kind_i == bcc_pkg::KIND_ACK) |=>
      (!single_click_o && !double_click_o && !long_click_o))
    else $error("acknowledge did not clear the flags");

  a_pressed_follows_pin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (pressed_now_o == !$past(pin_level_i)))
    else $error("pressed level does not match the request");

  // A press in idle restarts the count, so only released levels are covered.
  a_idle_count_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && state_q.phase == bcc_pkg::PH_IDLE && pin_level_i) |=>
      $stable(state_q.elapsed))
    else $error("tick count moved while idle");

endmodule
